// ===== hdl/rrfr_pkg.sv =====
package rrfr_pkg;

    localparam int RING_BYTES_DEF     = 16384;
    localparam int TAIL_THRESHOLD_DEF = 16;

    localparam int HDR_BYTES     = 4;
    localparam int HDR_CRC_BYTES = 8;

    localparam int OFF_W  = 14;
    localparam int ADDR_W = 4;

    localparam logic [15:0] OK_MASK_RST = 16'h0001;
    localparam logic [15:0] MARKER_RST  = 16'hFFF0;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_OK_MASK = 2'd1,
        REG_MARKER  = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_NOTHING   = 3'd0,
        ST_COPYING   = 3'd1,
        ST_DELIVERED = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_RESYNCED  = 3'd4
    } t_status;

    typedef struct packed {
        logic        enable;
        logic [15:0] status_ok_mask;
        logic [15:0] copying_marker;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic        ring_empty;
        logic [15:0] header_status;
        logic [15:0] header_length;
        logic [15:0] request_len;
        logic        dest_valid;
        logic [15:0] head_pointer;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [15:0]      returned_len;
        logic [OFF_W-1:0] copy_offset;
        logic [15:0]      first_len;
        logic [15:0]      second_len;
        logic [OFF_W-1:0] header_offset;
        logic             tail_write;
        logic [15:0]      tail_value;
    } t_result;

endpackage

// ===== hdl/rrfr_cfg.sv =====
module rrfr_cfg
    import rrfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.status_ok_mask <= OK_MASK_RST;
            r_cfg.copying_marker <= MARKER_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ENABLE:  r_cfg.enable         <= pwdata[0];
                REG_OK_MASK: r_cfg.status_ok_mask <= pwdata[15:0];
                REG_MARKER:  r_cfg.copying_marker <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ENABLE:  prdata = {31'd0, r_cfg.enable};
            REG_OK_MASK: prdata = {16'd0, r_cfg.status_ok_mask};
            REG_MARKER:  prdata = {16'd0, r_cfg.copying_marker};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/rrfr_calc.sv =====
module rrfr_calc
    import rrfr_pkg::*;
#(
    parameter int RING_BYTES     = RING_BYTES_DEF,
    parameter int TAIL_THRESHOLD = TAIL_THRESHOLD_DEF,
    localparam int RW            = $clog2(RING_BYTES)
) (
    input  t_cfg           i_cfg,
    input  t_item          i_item,
    input  logic [RW-1:0]  i_read_offset,
    input  logic [15:0]    i_chunk_index,
    output t_result        o_result,
    output logic [RW-1:0]  o_read_offset,
    output logic [15:0]    o_chunk_index
);

    logic [15:0] w_frame;
    logic [15:0] w_rest;
    logic [15:0] w_len;
    logic        w_good;
    logic [RW-1:0] w_coff;
    logic [RW:0]   w_to_end;
    logic          w_fits;
    logic [15:0]   w_ci_next;
    logic [RW-1:0] w_next_sum;
    logic [RW-1:0] w_next_hdr;
    logic [RW-1:0] w_head;

    function automatic logic [15:0] tail_of(input logic [RW-1:0] off);
        logic [RW-1:0] t;
        t = off - RW'(TAIL_THRESHOLD);
        return 16'(t);
    endfunction

    assign w_frame   = i_item.header_length - 16'(HDR_BYTES);
    assign w_rest    = (i_chunk_index < w_frame) ? (w_frame - i_chunk_index) : 16'd0;
    assign w_len     = (i_item.request_len > w_rest) ? w_rest : i_item.request_len;
    assign w_good    = (|(i_item.header_status & i_cfg.status_ok_mask)) && i_item.dest_valid
                       && (w_len != 16'd0);
    assign w_coff    = i_read_offset + RW'(HDR_BYTES) + i_chunk_index[RW-1:0];
    assign w_to_end  = (RW+1)'(RING_BYTES) - {1'b0, w_coff};
    assign w_fits    = 17'(w_len) < 17'(w_to_end);
    assign w_ci_next = w_good ? (i_chunk_index + w_len) : w_frame;
    assign w_next_sum = i_read_offset + w_frame[RW-1:0] + RW'(HDR_CRC_BYTES + 3);
    assign w_next_hdr = {w_next_sum[RW-1:2], 2'b00};
    assign w_head    = i_item.head_pointer[RW-1:0];

    always_comb begin
        o_result      = '0;
        o_read_offset = i_read_offset;
        o_chunk_index = i_chunk_index;
        o_result.status = ST_NOTHING;
        if (!i_cfg.enable) begin
            o_result.status = ST_NOTHING;
        end else if (i_item.mode) begin
            o_read_offset       = w_head;
            o_chunk_index       = 16'd0;
            o_result.status     = ST_RESYNCED;
            o_result.tail_write = 1'b1;
            o_result.tail_value = tail_of(w_head);
        end else if (i_item.ring_empty) begin
            o_result.status = ST_NOTHING;
        end else if (i_item.header_length == i_cfg.copying_marker) begin
            o_result.status = ST_COPYING;
        end else if (i_item.header_length <= 16'(HDR_BYTES)) begin
            o_result.status = ST_NOTHING;
        end else begin
            if (w_good) begin
                o_result.status       = ST_DELIVERED;
                o_result.returned_len = w_len;
                o_result.copy_offset  = OFF_W'(w_coff);
                if (w_fits) begin
                    o_result.first_len  = w_len;
                    o_result.second_len = 16'd0;
                end else begin
                    o_result.first_len  = 16'(w_to_end);
                    o_result.second_len = w_len - 16'(w_to_end);
                end
            end else begin
                o_result.status = ST_DROPPED;
            end
            o_chunk_index = w_ci_next;
            if (w_ci_next >= w_frame) begin
                o_read_offset       = w_next_hdr;
                o_chunk_index       = 16'd0;
                o_result.tail_write = 1'b1;
                o_result.tail_value = tail_of(w_next_hdr);
            end
        end
        o_result.header_offset = OFF_W'(o_read_offset);
    end

endmodule

// ===== hdl/rx_ring_frame_reader.sv =====
// Receive ring frame reader.
// An accepted item passes the input register, then the result register; the
// header/length arithmetic sits between them.
// One item per cycle unless i_ready stalls the output; the state updates per item.
// Reset (synchronous, active low) clears both stages, the header offset and
// the frame index, and loads the register defaults.
module rx_ring_frame_reader
    import rrfr_pkg::*;
#(
    parameter int RING_BYTES     = RING_BYTES_DEF,
    parameter int TAIL_THRESHOLD = TAIL_THRESHOLD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic              i_ring_empty,
    input  logic [15:0]       i_header_status,
    input  logic [15:0]       i_header_length,
    input  logic [15:0]       i_request_len,
    input  logic              i_dest_valid,
    input  logic [15:0]       i_head_pointer,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [15:0]       o_returned_len,
    output logic [OFF_W-1:0]  o_copy_offset,
    output logic [15:0]       o_first_len,
    output logic [15:0]       o_second_len,
    output logic [OFF_W-1:0]  o_header_offset,
    output logic              o_tail_write,
    output logic [15:0]       o_tail_value
);

    localparam int RW = $clog2(RING_BYTES);

    t_cfg          w_cfg;
    logic          r_in_valid;
    t_item         r_item;
    logic [RW-1:0] r_read_offset;
    logic [15:0]   r_chunk_index;
    logic          r_out_valid;
    t_result       r_res;
    t_result       n_res;
    logic [RW-1:0] n_read_offset;
    logic [15:0]   n_chunk_index;
    logic          w_adv;
    logic          w_out_free;

    rrfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rrfr_calc #(
        .RING_BYTES     (RING_BYTES),
        .TAIL_THRESHOLD (TAIL_THRESHOLD)
    ) u_calc (
        .i_cfg         (w_cfg),
        .i_item        (r_item),
        .i_read_offset (r_read_offset),
        .i_chunk_index (r_chunk_index),
        .o_result      (n_res),
        .o_read_offset (n_read_offset),
        .o_chunk_index (n_chunk_index)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_ready    = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_read_offset <= '0;
            r_chunk_index <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_read_offset <= n_read_offset;
                r_chunk_index <= n_chunk_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.mode          <= i_mode;
            r_item.ring_empty    <= i_ring_empty;
            r_item.header_status <= i_header_status;
            r_item.header_length <= i_header_length;
            r_item.request_len   <= i_request_len;
            r_item.dest_valid    <= i_dest_valid;
            r_item.head_pointer  <= i_head_pointer;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_res.status;
    assign o_returned_len  = r_res.returned_len;
    assign o_copy_offset   = r_res.copy_offset;
    assign o_first_len     = r_res.first_len;
    assign o_second_len    = r_res.second_len;
    assign o_header_offset = r_res.header_offset;
    assign o_tail_write    = r_res.tail_write;
    assign o_tail_value    = r_res.tail_value;

endmodule

// ===== tb/rrfr_tb_pkg.sv =====
package rrfr_tb_pkg;
    import rrfr_pkg::*;

    localparam int unsigned RING = RING_BYTES_DEF;
    localparam int unsigned THRESH = TAIL_THRESHOLD_DEF;

    class frame_sb;
        bit          en;
        logic [15:0] ok_mask;
        logic [15:0] marker;
        int unsigned rd_off;
        int unsigned idx;
        t_result     exp_q[$];
        int          mismatches;

        function new();
            en = 1'b0;
            ok_mask = OK_MASK_RST;
            marker = MARKER_RST;
            rd_off = 0;
            idx = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_reg_idx r, logic [31:0] v);
            case (r)
                REG_ENABLE:  en = v[0];
                REG_OK_MASK: ok_mask = v[15:0];
                REG_MARKER:  marker = v[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return exp_q.size();
        endfunction

        function logic [15:0] tail_of(int unsigned off);
            return 16'((off + RING - THRESH) % RING);
        endfunction

        // Advance the frame state for one accepted item and queue its result.
        function t_status note_item(t_item it);
            t_result     r;
            int unsigned frame;
            int unsigned rest;
            int unsigned len;
            int unsigned coff;
            int unsigned to_end;
            r = '0;
            r.status = ST_NOTHING;
            if (!en) begin
                r.status = ST_NOTHING;
            end else if (it.mode) begin
                rd_off = it.head_pointer % RING;
                idx = 0;
                r.status = ST_RESYNCED;
                r.tail_write = 1'b1;
                r.tail_value = tail_of(rd_off);
            end else if (it.ring_empty) begin
                r.status = ST_NOTHING;
            end else if (it.header_length == marker) begin
                r.status = ST_COPYING;
            end else if (it.header_length <= HDR_BYTES) begin
                r.status = ST_NOTHING;
            end else begin
                frame = it.header_length - HDR_BYTES;
                rest = (idx < frame) ? frame - idx : 0;
                len = (it.request_len > rest) ? rest : it.request_len;
                if ((it.header_status & ok_mask) != 16'd0 && it.dest_valid && len != 0) begin
                    coff = (rd_off + HDR_BYTES + idx) % RING;
                    to_end = RING - coff;
                    if (len < to_end) begin
                        r.first_len = 16'(len);
                    end else begin
                        r.first_len = 16'(to_end);
                        r.second_len = 16'(len - to_end);
                    end
                    idx = (idx + len) & 32'hFFFF;
                    r.returned_len = 16'(len);
                    r.copy_offset = OFF_W'(coff);
                    r.status = ST_DELIVERED;
                end else begin
                    idx = frame;
                    r.status = ST_DROPPED;
                end
                if (idx >= frame) begin
                    rd_off = ((rd_off + frame + HDR_CRC_BYTES + 3) & ~32'd3) % RING;
                    idx = 0;
                    r.tail_write = 1'b1;
                    r.tail_value = tail_of(rd_off);
                end
            end
            r.header_offset = OFF_W'(rd_off);
            exp_q.push_back(r);
            return r.status;
        endfunction

        function void check_result(t_result got);
            t_result e;
            bit      bad;
            if (exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d ret=%0d hoff=%0d",
                             got.status, got.returned_len, got.header_offset);
                return;
            end
            e = exp_q.pop_front();
            bad = (got.status !== e.status) || (got.returned_len !== e.returned_len) ||
                  (got.copy_offset !== e.copy_offset) || (got.first_len !== e.first_len) ||
                  (got.second_len !== e.second_len) ||
                  (got.header_offset !== e.header_offset) ||
                  (got.tail_write !== e.tail_write) || (got.tail_value !== e.tail_value);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: exp st=%0d ret=%0d coff=%0d l1=%0d l2=%0d hoff=%0d tw=%0d tv=%0d",
                             e.status, e.returned_len, e.copy_offset, e.first_len,
                             e.second_len, e.header_offset, e.tail_write, e.tail_value);
                    $display("                 got st=%0d ret=%0d coff=%0d l1=%0d l2=%0d hoff=%0d tw=%0d tv=%0d",
                             got.status, got.returned_len, got.copy_offset, got.first_len,
                             got.second_len, got.header_offset, got.tail_write, got.tail_value);
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
module tb_top;
    import rrfr_pkg::*;
    import rrfr_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 4000;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_mode = 1'b0;
    logic              i_ring_empty = 1'b0;
    logic [15:0]       i_header_status = '0;
    logic [15:0]       i_header_length = '0;
    logic [15:0]       i_request_len = '0;
    logic              i_dest_valid = 1'b0;
    logic [15:0]       i_head_pointer = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [2:0]        o_status;
    logic [15:0]       o_returned_len;
    logic [OFF_W-1:0]  o_copy_offset;
    logic [15:0]       o_first_len;
    logic [15:0]       o_second_len;
    logic [OFF_W-1:0]  o_header_offset;
    logic              o_tail_write;
    logic [15:0]       o_tail_value;

    frame_sb sb = new();
    bit      quiet = 1'b0;
    int      useful = 0;
    int      stall_left = 0;
    int      idle_cycles = 0;

    rx_ring_frame_reader i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_ring_empty    (i_ring_empty),
        .i_header_status (i_header_status),
        .i_header_length (i_header_length),
        .i_request_len   (i_request_len),
        .i_dest_valid    (i_dest_valid),
        .i_head_pointer  (i_head_pointer),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_returned_len  (o_returned_len),
        .o_copy_offset   (o_copy_offset),
        .o_first_len     (o_first_len),
        .o_second_len    (o_second_len),
        .o_header_offset (o_header_offset),
        .o_tail_write    (o_tail_write),
        .o_tail_value    (o_tail_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : rx_side
        t_result got;
        logic    nxt;
        if (o_valid && i_ready) begin
            got.status = t_status'(o_status);
            got.returned_len = o_returned_len;
            got.copy_offset = o_copy_offset;
            got.first_len = o_first_len;
            got.second_len = o_second_len;
            got.header_offset = o_header_offset;
            got.tail_write = o_tail_write;
            got.tail_value = o_tail_value;
            sb.check_result(got);
        end
        if (!i_rst_n) begin
            nxt = 1'b0;
        end else if (quiet) begin
            nxt = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b0;
        end else if ($urandom_range(0, 99) < 10) begin
            stall_left = $urandom_range(1, 18) - 1;
            nxt = 1'b0;
        end else begin
            nxt = 1'b1;
        end
        i_ready <= nxt;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_item mk_item(logic m, logic e, logic [15:0] hs, logic [15:0] hl,
                                      logic [15:0] rq, logic dv, logic [15:0] hp);
        t_item it;
        it.mode = m;
        it.ring_empty = e;
        it.header_status = hs;
        it.header_length = hl;
        it.request_len = rq;
        it.dest_valid = dv;
        it.head_pointer = hp;
        return it;
    endfunction

    task automatic send_item(t_item it);
        int       gap;
        t_status  st;
        gap = (!quiet && $urandom_range(0, 99) < 12) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= it.mode;
        i_ring_empty <= it.ring_empty;
        i_header_status <= it.header_status;
        i_header_length <= it.header_length;
        i_request_len <= it.request_len;
        i_dest_valid <= it.dest_valid;
        i_head_pointer <= it.head_pointer;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        st = sb.note_item(it);
        if (st != ST_NOTHING) useful++;
    endtask

    task automatic apb_write(t_reg_idx r, logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(int'(r) * 4);
        pwdata <= {16'h0000, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(r, {16'h0000, v});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(logic en, logic [15:0] mask, logic [15:0] mk);
        drain();
        apb_write(REG_ENABLE, {15'd0, en});
        apb_write(REG_OK_MASK, mask);
        apb_write(REG_MARKER, mk);
        @(posedge i_clk);
    endtask

    task automatic send_noise();
        logic [15:0] hp;
        case ($urandom_range(0, 5))
            0: send_item(mk_item(1'b1, 1'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 1'($urandom), 16'($urandom)));
            1: begin
                hp = 16'(RING * $urandom_range(0, 3) + RING - $urandom_range(1, 64));
                send_item(mk_item(1'b1, 1'b0, 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'b1, hp));
            end
            2: send_item(mk_item(1'b0, 1'b1, 16'($urandom), 16'($urandom),
                                 16'($urandom), 1'($urandom), 16'($urandom)));
            3: send_item(mk_item(1'b0, 1'b0, 16'($urandom), sb.marker,
                                 16'($urandom), 1'($urandom), 16'($urandom)));
            4: send_item(mk_item(1'b0, 1'b0, 16'($urandom), 16'($urandom_range(0, 4)),
                                 16'($urandom), 1'($urandom), 16'($urandom)));
            default: send_item(mk_item(1'($urandom), 1'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom), 1'($urandom),
                                       16'($urandom)));
        endcase
    endtask

    // Frames are read in up to 12 requests until consumed; the header length may change.
    task automatic run_frames(int goal);
        int          roll;
        int          reads;
        logic [15:0] hl;
        logic [15:0] hs;
        logic [15:0] rq;
        while (useful < goal) begin
            if ($urandom_range(0, 99) < 80) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) hl = 16'($urandom_range(5, 8));
                else if (roll < 75) hl = 16'($urandom_range(9, 400));
                else if (roll < 93) hl = 16'($urandom_range(401, 3000));
                else hl = 16'($urandom_range(3001, 65535));
                if (hl == sb.marker) hl = hl + 16'd1;
                hs = 16'($urandom);
                if ($urandom_range(0, 99) < 85) hs = hs | sb.ok_mask;
                else hs = hs & ~sb.ok_mask;
                reads = 0;
                do begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10) rq = 16'd0;
                    else if (roll < 60) rq = 16'($urandom_range(1, hl / 2 + 1));
                    else if (roll < 85) rq = 16'($urandom_range(1, hl));
                    else rq = 16'($urandom);
                    send_item(mk_item(1'b0, 1'b0, hs, hl, rq, $urandom_range(0, 19) != 0,
                                      16'($urandom)));
                    reads++;
                    if ($urandom_range(0, 99) < 3) hl = 16'($urandom_range(5, 64));
                end while (sb.idx != 0 && reads < 12);
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset, resync included
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd100, 16'd10, 1'b1, 16'h0000));
        send_item(mk_item(1'b1, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 16'h1234));
        send_item(mk_item(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));

        set_regs(1'b1, OK_MASK_RST, MARKER_RST);
        send_item(mk_item(1'b0, 1'b1, 16'h0001, 16'd100, 16'd10, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'hFFF0, 16'd10, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd4, 16'd10, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd0, 16'd10, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd5, 16'd1, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0000, 16'd100, 16'd10, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd100, 16'd10, 1'b0, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd100, 16'd0, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'hFFFF, 16'd200, 16'd50, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'hFFFF, 16'd200, 16'hFFFF, 1'b1, 16'h0000));
        // exactly to the ring end
        send_item(mk_item(1'b1, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 16'd16360));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd100, 16'd20, 1'b1, 16'h0000));
        // split across the ring end, then header shrinks under the index
        send_item(mk_item(1'b1, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 16'd16370));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd2000, 16'd1000, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'd10, 16'd100, 1'b1, 16'h0000));
        // segment longer than the ring
        send_item(mk_item(1'b1, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 16'hFFFF));
        send_item(mk_item(1'b0, 1'b0, 16'h0001, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000));
        send_item(mk_item(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000));
        send_item(mk_item(1'b0, 1'b0, 16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b1, 16'hFFFF));
        send_item(mk_item(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000));

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(1'b1, 16'h0001, 16'hFFF0);
                1: set_regs(1'b1, 16'hFFFF, 16'h0000);
                2: set_regs(1'b1, 16'h0000, 16'hFFFF);
                3: begin
                    set_regs(1'b0, 16'($urandom), 16'($urandom));
                    repeat (15) send_noise();
                    set_regs(1'b1, 16'($urandom), 16'($urandom_range(0, 300)));
                end
                4: set_regs(1'b1, 16'h8000, 16'h0005);
                5: set_regs(1'b1, 16'($urandom), 16'($urandom));
                6: set_regs(1'b1, 16'h00FF, 16'hFFF0);
                default: begin
                    quiet = 1'b1;
                    set_regs(1'b1, 16'hFFFE, 16'($urandom));
                end
            endcase
            run_frames(112 * (ph + 1));
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
